// ----- sv/x86ild_pkg.sv -----
// Shared types, constants and opcode tables of the x86-64 length decoder.
package x86ild_pkg;

  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhPfx   = 3'd1,
    PhEsc   = 3'd2,
    PhMap3  = 3'd3,
    PhModrm = 3'd4,
    PhSib   = 3'd5
  } phase_e;

  // opcode map codes
  localparam logic [1:0] MapOneByte = 2'd0;
  localparam logic [1:0] Map0F      = 2'd1;
  localparam logic [1:0] Map0F38    = 2'd2;
  localparam logic [1:0] Map0F3A    = 2'd3;

  // table flag bits
  localparam logic [7:0] FModrm = 8'h01;
  localparam logic [7:0] FImm8  = 8'h02;
  localparam logic [7:0] FImm16 = 8'h04;
  localparam logic [7:0] FImm32 = 8'h08;
  localparam logic [7:0] FRel8  = 8'h20;
  localparam logic [7:0] FRel32 = 8'h40;

  localparam logic [4:0] MaxLen = 5'd15;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  pos;
    logic        rex_w;
    logic        opsz;
    logic        adsz;
    logic [1:0]  map;
    logic [7:0]  opc;
    logic [7:0]  flags;
    logic [7:0]  modrm;
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [3:0]  len;
    logic        inv;
  } result_t;

  localparam logic [7:0] MapOne [256] = '{
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h80,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h80,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h80,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h08,8'h80,8'h00,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h01,8'h01,8'h80,8'h80,8'h80,8'h80,
    8'h08,8'h09,8'h02,8'h03,8'h00,8'h00,8'h00,8'h00,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h03,8'h09,8'h03,8'h03,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h0C,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h10,8'h10,8'h10,8'h10,8'h00,8'h00,8'h00,8'h00,
    8'h02,8'h08,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,8'h02,
    8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,
    8'h03,8'h03,8'h04,8'h00,8'h01,8'h01,8'h03,8'h09,
    8'h06,8'h00,8'h04,8'h00,8'h00,8'h02,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h02,8'h02,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h20,8'h20,8'h20,8'h20,8'h02,8'h08,8'h02,8'h08,
    8'h40,8'h40,8'h0C,8'h20,8'h00,8'h00,8'h00,8'h00,
    8'h80,8'h00,8'h80,8'h80,8'h00,8'h00,8'h01,8'h01,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h01
  };

  localparam logic [7:0] Map0FTab [256] = '{
    8'h01,8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h01,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h00,8'h00,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h01,8'h00,8'h01,8'h00,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h03,8'h03,8'h03,8'h03,8'h01,8'h01,8'h01,8'h00,
    8'h01,8'h01,8'h00,8'h00,8'h01,8'h01,8'h01,8'h01,
    8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,8'h40,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h00,8'h00,8'h00,8'h01,8'h03,8'h01,8'h00,8'h00,
    8'h00,8'h00,8'h00,8'h01,8'h03,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h00,8'h03,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h03,8'h01,8'h03,8'h03,8'h03,8'h01,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00
  };

endpackage

// ----- sv/x86ild_step.sv -----
// Per-byte parse step: next parse state and the length result, if any.
module x86ild_step
  import x86ild_pkg::*;
(
  input  state_t      st_i,
  input  logic [7:0]  byte_i,
  input  logic        sof_i,
  output state_t      st_o,
  output result_t     res_o
);

  state_t      cur;
  state_t      nxt;
  logic [4:0]  cnt;
  logic        fin;
  logic        more;
  logic        aft;
  logic        use_imm;
  logic        have_modrm;
  phase_e      nph;
  logic [5:0]  base;
  logic [5:0]  total;
  logic [4:0]  imm;
  logic [1:0]  mod_f;
  logic [2:0]  rm_f;
  logic        grp3;

  function automatic logic is_prefix(input logic [7:0] b);
    return (b == 8'hF0) || (b == 8'hF2) || (b == 8'hF3) || (b == 8'h2E) ||
           (b == 8'h36) || (b == 8'h3E) || (b == 8'h26) || (b == 8'h64) ||
           (b == 8'h65) || (b == 8'h66) || (b == 8'h67) || (b[7:4] == 4'h4);
  endfunction

  function automatic logic [4:0] imm_bytes(input logic [7:0] fl, input logic opsz,
                                           input logic g3, input logic is_f6);
    logic [4:0] w;
    logic [4:0] n;
    w = opsz ? 5'd2 : 5'd4;
    n = '0;
    if (g3)               n = n + (is_f6 ? 5'd1 : w);
    if ((fl & FImm8)  != 0) n = n + 5'd1;
    if ((fl & FImm16) != 0) n = n + 5'd2;
    if ((fl & FImm32) != 0) n = n + w;
    if ((fl & FRel8)  != 0) n = n + 5'd1;
    if ((fl & FRel32) != 0) n = n + 5'd4;
    return n;
  endfunction

  always_comb begin
    cur        = st_i;
    fin        = 1'b0;
    more       = 1'b0;
    aft        = 1'b0;
    use_imm    = 1'b0;
    have_modrm = 1'b0;
    nph        = PhIdle;
    base       = '0;
    mod_f      = 2'd0;
    rm_f       = 3'd0;
    if (sof_i) begin
      cur       = '0;
      cur.phase = PhPfx;
    end
    nxt = cur;
    cnt = {1'b0, cur.pos} + 5'd1;

    unique case (cur.phase)
      PhPfx: begin
        if (is_prefix(byte_i)) begin
          if (byte_i == 8'h66) nxt.opsz = 1'b1;
          if (byte_i == 8'h67) nxt.adsz = 1'b1;
          if (byte_i[7:4] == 4'h4 && byte_i[3]) nxt.rex_w = 1'b1;
          more = 1'b1;
          nph  = PhPfx;
        end else begin
          nxt.opc = byte_i;
          if (byte_i == 8'h0F) begin
            more = 1'b1;
            nph  = PhEsc;
          end else begin
            nxt.map   = MapOneByte;
            nxt.flags = MapOne[byte_i];
            if (byte_i >= 8'hA0 && byte_i <= 8'hA3) begin
              // moffs width follows the address size
              fin  = 1'b1;
              base = {1'b0, cnt} + (cur.adsz ? 6'd4 : 6'd8);
            end else if (byte_i >= 8'hB8 && byte_i <= 8'hBF) begin
              fin  = 1'b1;
              base = {1'b0, cnt} + (cur.rex_w ? 6'd8 : 6'd4);
            end else begin
              aft = 1'b1;
            end
          end
        end
      end
      PhEsc: begin
        if (byte_i == 8'h38 || byte_i == 8'h3A) begin
          nxt.map = (byte_i == 8'h38) ? Map0F38 : Map0F3A;
          more    = 1'b1;
          nph     = PhMap3;
        end else begin
          nxt.map   = Map0F;
          nxt.opc   = byte_i;
          nxt.flags = Map0FTab[byte_i];
          aft       = 1'b1;
        end
      end
      PhMap3: begin
        nxt.opc   = byte_i;
        nxt.flags = FModrm | ((cur.map == Map0F3A) ? FImm8 : 8'h00);
        aft       = 1'b1;
      end
      PhModrm: begin
        nxt.modrm = byte_i;
        mod_f     = byte_i[7:6];
        rm_f      = byte_i[2:0];
        if (rm_f == 3'd4 && mod_f != 2'd3) begin
          more = 1'b1;
          nph  = PhSib;
        end else begin
          fin        = 1'b1;
          use_imm    = 1'b1;
          have_modrm = 1'b1;
          base = {1'b0, cnt} + ((mod_f == 2'd1) ? 6'd1 :
                                (mod_f == 2'd2) ? 6'd4 :
                                (mod_f == 2'd0 && rm_f == 3'd5) ? 6'd4 : 6'd0);
        end
      end
      PhSib: begin
        mod_f      = cur.modrm[7:6];
        fin        = 1'b1;
        use_imm    = 1'b1;
        have_modrm = 1'b1;
        base = {1'b0, cnt} + ((mod_f == 2'd1) ? 6'd1 : (mod_f == 2'd2) ? 6'd4 : 6'd0)
                           + ((mod_f == 2'd0 && byte_i[2:0] == 3'd5) ? 6'd4 : 6'd0);
      end
      default: begin
        // no open parse: drop the byte
        nxt.phase = PhIdle;
      end
    endcase

    // opcode done: fetch ModR/M or close out with the immediate
    if (aft) begin
      if ((nxt.flags & FModrm) != 0) begin
        more = 1'b1;
        nph  = PhModrm;
      end else begin
        fin     = 1'b1;
        use_imm = 1'b1;
        base    = {1'b0, cnt};
      end
    end

    grp3 = have_modrm && (nxt.map == MapOneByte) && (nxt.opc == 8'hF6 || nxt.opc == 8'hF7) &&
           (nxt.modrm[5:4] == 2'b00);
    imm  = imm_bytes(nxt.flags, nxt.opsz, grp3, nxt.opc == 8'hF6);
    total = base + (use_imm ? {1'b0, imm} : 6'd0);

    if (more) begin
      if (cnt >= MaxLen) begin
        fin   = 1'b1;
        total = 6'd16;
      end else begin
        nxt.pos   = cnt[3:0];
        nxt.phase = nph;
      end
    end
    if (fin) nxt.phase = PhIdle;

    st_o      = nxt;
    res_o.valid = fin;
    res_o.inv   = (total > {1'b0, MaxLen});
    res_o.len   = res_o.inv ? 4'd0 : total[3:0];
  end

endmodule

// ----- sv/x86_64_instruction_length_decoder.sv -----
// Top level of the x86-64 instruction length decoder.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) moves one code byte per word, with
//    start_of_instruction_i marking the first byte of an instruction.
//  - Output channel (out_valid_o / out_stall_i) moves one length word per
//    decoded instruction: length_bytes_o, or is_invalid_o with length 0 when
//    the instruction would need more than 15 bytes.
//  - A byte is taken every cycle while in_stall_o is low. It lands in the
//    input register, is parsed in the next cycle, and its result (if it
//    decides the length) is written to the output register, which raises
//    out_valid_o until the word is taken.
//  - Throughput is one byte per cycle when not stalled, set by the single parse
//    step between the input register and the parse state register.
//  - Bytes after the deciding byte are dropped until the next start byte;
//    a new start abandons an undecided parse silently.
//  - When the receiver stalls, the output word holds; bytes that decide no
//    length keep flowing, and only a byte that would emit a second result
//    waits in the input register and raises in_stall_o.
//  - Reset clears the parse state to idle and empties both registers.
module x86_64_instruction_length_decoder
  import x86ild_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  code_byte_i,
  input  logic        start_of_instruction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  length_bytes_o,
  output logic        is_invalid_o
);

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        sof_q;
  state_t      st_q;
  state_t      st_d;
  result_t     res;
  logic        out_valid_q;
  logic [3:0]  len_q;
  logic        inv_q;
  logic        blocked;
  logic        adv;

  x86ild_step u_step (
    .st_i   (st_q),
    .byte_i (byte_q),
    .sof_i  (sof_q),
    .st_o   (st_d),
    .res_o  (res)
  );

  // hold the byte only when its result has nowhere to go
  assign blocked    = res.valid && out_valid_q && out_stall_i;
  assign adv        = in_valid_q && !blocked;
  assign in_stall_o = in_valid_q && blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= code_byte_i;
      sof_q  <= start_of_instruction_i;
    end
  end

  // advance parse state once per consumed byte; all-zero state is idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      len_q <= res.len;
      inv_q <= res.inv;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign length_bytes_o = len_q;
  assign is_invalid_o   = inv_q;

endmodule

// ----- dv/x86ild_length_checker.sv -----
// Checker for the x86-64 length decoder: predicts each length word and compares it.
module x86ild_length_checker
  import x86ild_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] code_byte_i,
  input  logic       start_of_instruction_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [3:0] length_bytes_i,
  input  logic       is_invalid_i,
  output int         fails_o,
  output int         due_o,
  output int         checked_o,
  output int         invalid_o
);

  localparam logic [7:0] EscapeByte  = 8'h0F;
  localparam logic [7:0] Esc38Byte   = 8'h38;
  localparam logic [7:0] Esc3AByte   = 8'h3A;
  localparam logic [7:0] OpSizePfx   = 8'h66;
  localparam logic [7:0] AddrSizePfx = 8'h67;
  localparam logic [3:0] RexHigh     = 4'h4;
  localparam logic [7:0] MoffsFirst  = 8'hA0;
  localparam logic [7:0] MoffsLast   = 8'hA3;
  localparam logic [7:0] MovImmFirst = 8'hB8;
  localparam logic [7:0] MovImmLast  = 8'hBF;
  localparam logic [7:0] Grp3Byte    = 8'hF6;
  localparam logic [7:0] Grp3Word    = 8'hF7;
  localparam logic [7:0] LegacyPrefixes [11] = '{
    8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67
  };

  state_t  dec;
  result_t due_lengths [$];
  int      fails;
  int      checked;
  int      invalids;

  function automatic bit is_legacy(input logic [7:0] b);
    foreach (LegacyPrefixes[i]) if (b == LegacyPrefixes[i]) return 1'b1;
    return 1'b0;
  endfunction

  // Bytes of immediate and relative operand after the opcode and addressing bytes.
  function automatic int imm_len(input bit with_modrm);
    int n;
    int w;
    n = 0;
    w = dec.opsz ? 2 : 4;
    // group 3 TEST carries an immediate only for reg 0 and 1
    if (with_modrm && dec.map == MapOneByte && (dec.opc == Grp3Byte || dec.opc == Grp3Word)
        && dec.modrm[5:4] == 2'b00)
      n += (dec.opc == Grp3Byte) ? 1 : w;
    if ((dec.flags & FImm8) != 0)  n += 1;
    if ((dec.flags & FImm16) != 0) n += 2;
    if ((dec.flags & FImm32) != 0) n += w;
    if ((dec.flags & FRel8) != 0)  n += 1;
    if ((dec.flags & FRel32) != 0) n += 4;
    return n;
  endfunction

  // Advance the decoder copy by one byte; the valid bit marks a decided length.
  function automatic result_t decode_byte(input logic [7:0] b, input logic sof);
    result_t    r;
    logic [4:0] cnt;
    int         total;
    int         disp;
    bit         closed;
    bit         opc_done;
    phase_e     nxt;
    r = '0;
    total = 0;
    disp = 0;
    closed = 1'b0;
    opc_done = 1'b0;
    nxt = PhIdle;
    if (sof) begin
      dec = '0;
      dec.phase = PhPfx;
    end else if (dec.phase == PhIdle) begin
      return r;
    end
    cnt = {1'b0, dec.pos} + 5'd1;

    case (dec.phase)
      PhPfx: begin
        if (is_legacy(b) || b[7:4] == RexHigh) begin
          if (b == OpSizePfx) dec.opsz = 1'b1;
          if (b == AddrSizePfx) dec.adsz = 1'b1;
          if (b[7:4] == RexHigh && b[3]) dec.rex_w = 1'b1;
          nxt = PhPfx;
        end else begin
          dec.opc = b;
          if (b == EscapeByte) begin
            nxt = PhEsc;
          end else begin
            dec.map = MapOneByte;
            dec.flags = MapOne[b];
            if (b >= MoffsFirst && b <= MoffsLast) begin
              closed = 1'b1;
              total = cnt + (dec.adsz ? 4 : 8);
            end else if (b >= MovImmFirst && b <= MovImmLast) begin
              closed = 1'b1;
              total = cnt + (dec.rex_w ? 8 : 4);
            end else begin
              opc_done = 1'b1;
            end
          end
        end
      end
      PhEsc: begin
        if (b == Esc38Byte || b == Esc3AByte) begin
          dec.map = (b == Esc38Byte) ? Map0F38 : Map0F3A;
          nxt = PhMap3;
        end else begin
          dec.map = Map0F;
          dec.opc = b;
          dec.flags = Map0FTab[b];
          opc_done = 1'b1;
        end
      end
      PhMap3: begin
        dec.opc = b;
        dec.flags = FModrm | ((dec.map == Map0F3A) ? FImm8 : 8'h00);
        opc_done = 1'b1;
      end
      PhModrm: begin
        dec.modrm = b;
        if (b[2:0] == 3'd4 && b[7:6] != 2'd3) begin
          nxt = PhSib;
        end else begin
          disp = (b[7:6] == 2'd1) ? 1 : (b[7:6] == 2'd2) ? 4 :
                 (b[7:6] == 2'd0 && b[2:0] == 3'd5) ? 4 : 0;
          closed = 1'b1;
          total = cnt + disp + imm_len(1'b1);
        end
      end
      default: begin
        disp = (dec.modrm[7:6] == 2'd1) ? 1 : (dec.modrm[7:6] == 2'd2) ? 4 : 0;
        if (dec.modrm[7:6] == 2'd0 && b[2:0] == 3'd5) disp += 4;
        closed = 1'b1;
        total = cnt + disp + imm_len(1'b1);
      end
    endcase

    if (opc_done) begin
      if ((dec.flags & FModrm) != 0) begin
        nxt = PhModrm;
      end else begin
        closed = 1'b1;
        total = cnt + imm_len(1'b0);
      end
    end
    // another byte is needed but fifteen are already used
    if (!closed && cnt >= MaxLen) begin
      closed = 1'b1;
      total = MaxLen + 1;
    end
    if (closed) begin
      dec.phase = PhIdle;
      r.valid = 1'b1;
      if (total > MaxLen) r.inv = 1'b1;
      else r.len = 4'(total);
    end else begin
      dec.pos = cnt[3:0];
      dec.phase = nxt;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      dec = '0;
      due_lengths.delete();
      fails = 0;
      checked = 0;
      invalids = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        want = decode_byte(code_byte_i, start_of_instruction_i);
        if (want.valid) due_lengths.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        if (due_lengths.size() == 0) begin
          $display("%0t: unexpected length word: length %0d, invalid %b",
                   $time, length_bytes_i, is_invalid_i);
          fails++;
        end else begin
          want = due_lengths.pop_front();
          checked++;
          if (want.inv) invalids++;
          if (length_bytes_i !== want.len) begin
            $display("%0t: length_bytes mismatch: expected %0d, actual %0d",
                     $time, want.len, length_bytes_i);
            fails++;
          end
          if (is_invalid_i !== want.inv) begin
            $display("%0t: is_invalid mismatch: expected %b, actual %b",
                     $time, want.inv, is_invalid_i);
            fails++;
          end
        end
      end
    end
    fails_o   <= fails;
    due_o     <= due_lengths.size();
    checked_o <= checked;
    invalid_o <= invalids;
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the x86-64 length decoder: clock, reset, byte stimulus and verdict.
module tb;

  localparam int ByteTarget   = 1800;  // instruction bytes to offer in the random part
  localparam int LongHold     = 400;   // cycles of the long output hold-off
  localparam int IdleLimit    = 4000;  // cycles without any word moving before giving up
  localparam int SettleCycles = 8;     // covers the pipe from input register to output register with margin

  localparam logic [7:0] EscapeByte = 8'h0F;
  localparam logic [7:0] Esc38Byte  = 8'h38;
  localparam logic [7:0] Esc3AByte  = 8'h3A;
  localparam logic [7:0] MoffsBase  = 8'hA0;
  localparam logic [7:0] MovImmBase = 8'hB8;
  localparam logic [7:0] Grp3Base   = 8'hF6;
  localparam logic [7:0] RexBase    = 8'h40;
  localparam logic [7:0] LegacyPrefixes [11] = '{
    8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67
  };

  // Directed bytes: bit 8 is the start flag, bits 7:0 the code byte.
  localparam logic [8:0] Directed [26] = '{
    9'h000,                          // stray byte while idle: dropped
    9'h167, 9'h0A0,                  // 67 A0: moffs with 4-byte address, length 6
    9'h148, 9'h0B8,                  // REX.W MOV r,imm64, length 10
    9'h1F6, 9'h000,                  // F6 /0: TEST with imm8, length 3
    9'h166, 9'h0F7, 9'h0C8,          // 66 F7 /1: TEST with imm16, length 5
    9'h10F, 9'h038, 9'h000, 9'h0C0,  // 0F 38 map with ModR/M, length 4
    9'h10F, 9'h03A, 9'h00F, 9'h0C0,  // 0F 3A map with ModR/M and imm8, length 5
    9'h18B, 9'h004, 9'h025,          // SIB without base: disp32, length 7
    9'h1FF, 9'h0FF,                  // all-ones opcode and register ModR/M, length 2
    9'h10F,                          // escape left open: the next start abandons it
    9'h190,                          // single-byte opcode, length 1
    9'h0FF                           // byte after a decided length: dropped
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] code_byte = 8'h00;
  logic       sof = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [3:0] length_bytes;
  logic       is_invalid;

  int fails;
  int due;
  int checked;
  int invalids;

  int bytes_sent = 0;
  int core_bytes = 0;
  int insns      = 0;
  bit gappy      = 1'b0;  // sender inserts idle cycles between words
  bit hold_req   = 1'b0;  // ask the receiver for one long hold-off

  always #1 clk = ~clk;

  x86_64_instruction_length_decoder dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .code_byte_i            (code_byte),
    .start_of_instruction_i (sof),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .length_bytes_o         (length_bytes),
    .is_invalid_o           (is_invalid)
  );

  x86ild_length_checker u_checker (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_i             (in_stall),
    .code_byte_i            (code_byte),
    .start_of_instruction_i (sof),
    .out_valid_i            (out_valid),
    .out_stall_i            (out_stall),
    .length_bytes_i         (length_bytes),
    .is_invalid_i           (is_invalid),
    .fails_o                (fails),
    .due_o                  (due),
    .checked_o              (checked),
    .invalid_o              (invalids)
  );

  // Idle cycles after an accepted word: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (!gappy) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix legacy prefixes with REX bytes of any W and RXB.
  function automatic logic [7:0] pick_prefix();
    if ($urandom_range(0, 9) < 7) return LegacyPrefixes[$urandom_range(0, 10)];
    return RexBase + 8'($urandom_range(0, 15));
  endfunction

  // Offer one word and hold it until it is taken; keep valid high when no gap follows,
  // so the next word replaces the payload in the same step.
  task automatic put_byte(input logic [7:0] b, input logic s);
    int gap;
    in_valid  <= 1'b1;
    code_byte <= b;
    sof       <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every predicted length word has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due != 0);
  endtask

  // One instruction: prefixes, opcode in some map, then ModR/M, SIB and operand bytes.
  // Bytes past the deciding one get dropped by the block, as a real stream would have them.
  task automatic send_insn();
    logic [7:0] core [$];
    int npfx;
    int keep;
    // mostly a few prefixes; now and then a run long enough to hit the 15-byte limit
    npfx = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(0, 3);
    repeat (npfx) core.push_back(pick_prefix());
    case ($urandom_range(0, 9))
      0, 1: begin
        core.push_back(EscapeByte);
        core.push_back(8'($urandom));
      end
      2: begin
        core.push_back(EscapeByte);
        core.push_back(Esc38Byte);
        core.push_back(8'($urandom));
      end
      3: begin
        core.push_back(EscapeByte);
        core.push_back(Esc3AByte);
        core.push_back(8'($urandom));
      end
      4: core.push_back(MoffsBase + 8'($urandom_range(0, 3)));
      5: core.push_back(MovImmBase + 8'($urandom_range(0, 7)));
      6: core.push_back(Grp3Base + 8'($urandom_range(0, 1)));
      default: core.push_back(8'($urandom));
    endcase
    repeat ($urandom_range(2, 6)) core.push_back(8'($urandom));
    // cut some short so the next start abandons an open parse
    keep = ($urandom_range(0, 11) == 0) ? $urandom_range(1, core.size()) : core.size();
    for (int i = 0; i < keep; i++) put_byte(core[i], i == 0);
    core_bytes += keep;
  endtask

  // Raw bytes with a random start flag.
  task automatic send_noise();
    repeat ($urandom_range(1, 3)) put_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (Directed[i]) put_byte(Directed[i][7:0], Directed[i][8]);

    while (core_bytes < ByteTarget) begin
      // switch between gappy and back-to-back stretches
      if (insns % 40 == 0) gappy = ($urandom_range(0, 2) != 0);
      // hold the output off for a long stretch while bytes keep coming
      if (insns == 80) hold_req = 1'b1;
      // pause the sender until the pipe is empty
      if (insns == 160) drain();
      if ($urandom_range(0, 14) == 0) send_noise();
      else send_insn();
      insns++;
    end

    drain();
    repeat (SettleCycles) @(posedge clk);
    $display("Sent %0d code bytes (%0d random instructions) through prefixes, all maps,",
             bytes_sent, insns);
    $display("moffs, MOV imm and group 3 forms; %0d lengths compared, %0d of them invalid.",
             checked, invalids);
    if (fails == 0) begin
      $display("x86_64_instruction_length_decoder regression: pass");
    end else begin
      $display("x86_64_instruction_length_decoder regression: fail");
    end
    $finish;
  end

  // Receiver: free-flowing stretches, random short and long stalls, and one long hold-off
  // counted here so that the block fills up and stalls its input.
  initial begin : receiver
    int  span;
    bit  stall_now;
    forever begin
      if (hold_req) begin
        hold_req  = 1'b0;
        stall_now = 1'b1;
        span      = LongHold;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_now = 1'b0;
        span      = $urandom_range(20, 120);
      end else begin
        stall_now = ($urandom_range(0, 2) == 0);
        span      = (stall_now && $urandom_range(0, 19) == 0) ? $urandom_range(15, 60)
                                                              : $urandom_range(1, 3);
      end
      out_stall <= stall_now;
      repeat (span) @(posedge clk);
    end
  end

  // Watchdog: give up when no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
    $display("x86_64_instruction_length_decoder regression: fail");
    $finish;
  end

endmodule
